>>> rtl/text_console_writer_core_defines.svh
// Assertion macros for the text console writer core.
`ifndef TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer: same-cycle check failed");
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer: next-cycle check failed");
`else
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  localparam int REQ_W = 2;
  localparam int CODE_W = 8;
  localparam int CELL_ADDR_W = 13;
  localparam int CURSOR_W = 7;

  localparam logic [REQ_W-1:0] REQ_PUT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

  localparam logic [CODE_W-1:0] CODE_NUL = 8'd0;
  localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
  localparam logic [CODE_W-1:0] CODE_CR = 8'd13;
  localparam logic [CODE_W-1:0] CODE_SPACE = 8'd32;

  localparam logic [1:0] WSEL_CHAR = 2'd0;
  localparam logic [1:0] WSEL_ZERO = 2'd1;
  localparam logic [1:0] WSEL_SPACE = 2'd2;

  localparam logic RSEL_REQ = 1'b0;
  localparam logic RSEL_COPY = 1'b1;

  typedef struct packed {
    logic [REQ_W-1:0]       req_type;
    logic [CODE_W-1:0]      char_code;
    logic [CELL_ADDR_W-1:0] cell_address;
  } tcw_in_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_column;
    logic [CURSOR_W-1:0] cursor_row;
    logic [CODE_W-1:0]   cell_data;
  } tcw_out_t;

  typedef struct packed {
    logic       latch_in;
    logic       col_zero;
    logic       col_inc;
    logic       row_inc;
    logic       ptr_clr;
    logic       ptr_inc;
    logic       mem_we;
    logic [1:0] wsel;
    logic       rd_en;
    logic       rd_sel;
    logic       copy;
    logic       out_load;
  } tcw_cmd_t;

  typedef struct packed {
    logic is_put;
    logic is_clear;
    logic is_read;
    logic code_nul;
    logic code_cr;
    logic code_lf;
    logic col_wrap;
    logic row_last;
    logic ptr_copy_end;
    logic ptr_end;
  } tcw_status_t;

endpackage

>>> rtl/tcw_datapath.sv
// Datapath: screen memory, cursor registers, sweep pointer and result register.
module tcw_datapath import tcw_pkg::*; #(
  parameter int COLUMNS = 100,
  parameter int ROWS = 75
) (
  input  logic        clk,
  input  logic        rst_n,
  input  tcw_in_t     in_data,
  input  tcw_cmd_t    cmd,
  output tcw_status_t status,
  output tcw_out_t    out_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int COPY_LAST = COLUMNS * (ROWS - 1) - 1;

  logic [CODE_W-1:0] screen_mem [CELLS];

  logic [REQ_W-1:0]       req_r;
  logic [CODE_W-1:0]      code_r;
  logic [CELL_ADDR_W-1:0] addr_r;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [ADDR_W-1:0]      ptr_r, ptr_nxt;
  logic                   copy_pend_r;
  logic [ADDR_W-1:0]      copy_addr_r;
  logic [CODE_W-1:0]      rd_data_r;
  tcw_out_t               out_r;

  logic [ADDR_W-1:0]                 char_addr;
  logic [ADDR_W+CELL_ADDR_W-1:0]     req_addr_ext;
  logic                              rd_in_range;
  logic                              mem_we;
  logic [ADDR_W-1:0]                 mem_waddr;
  logic [CODE_W-1:0]                 mem_wdata;
  logic                              mem_re;
  logic [ADDR_W-1:0]                 mem_raddr;
  logic [15:0]                       col_ext;
  logic [15:0]                       row_ext;

  assign char_addr = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r));
  assign req_addr_ext = (ADDR_W + CELL_ADDR_W)'(addr_r);
  assign rd_in_range = (32'(addr_r) < 32'(CELLS));
  assign col_ext = 16'(col_r);
  assign row_ext = 16'(row_r);

  always_comb begin
    status.is_put = (req_r == REQ_PUT);
    status.is_clear = (req_r == REQ_CLEAR);
    status.is_read = (req_r == REQ_READ);
    status.code_nul = (code_r == CODE_NUL);
    status.code_cr = (code_r == CODE_CR);
    status.code_lf = (code_r == CODE_LF);
    status.col_wrap = (col_r == COL_W'(COLUMNS - 1));
    status.row_last = (row_r == ROW_W'(ROWS - 1));
    status.ptr_copy_end = (ptr_r == ADDR_W'(COPY_LAST));
    status.ptr_end = (ptr_r == ADDR_W'(CELLS - 1));
  end

  // A pending scroll copy owns the write port; the controller never writes then.
  always_comb begin
    if (copy_pend_r) begin
      mem_we = 1'b1;
      mem_waddr = copy_addr_r;
      mem_wdata = rd_data_r;
    end else begin
      mem_we = cmd.mem_we;
      mem_waddr = (cmd.wsel == WSEL_CHAR) ? char_addr : ptr_r;
      case (cmd.wsel)
        WSEL_CHAR: mem_wdata = code_r;
        WSEL_SPACE: mem_wdata = CODE_SPACE;
        default: mem_wdata = CODE_NUL;
      endcase
    end
  end

  always_comb begin
    if (cmd.rd_sel == RSEL_COPY) begin
      mem_re = cmd.rd_en;
      mem_raddr = ptr_r + ADDR_W'(COLUMNS);
    end else begin
      mem_re = cmd.rd_en && rd_in_range;
      mem_raddr = req_addr_ext[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= screen_mem[mem_raddr];
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    ptr_nxt = ptr_r;
    if (cmd.col_zero) begin
      col_nxt = '0;
    end else if (cmd.col_inc) begin
      col_nxt = col_r + COL_W'(1);
    end
    if (cmd.row_inc) begin
      row_nxt = row_r + ROW_W'(1);
    end
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ptr_r <= '0;
      copy_pend_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ptr_r <= ptr_nxt;
      copy_pend_r <= cmd.copy;
    end
  end

  always_ff @(posedge clk) begin
    copy_addr_r <= ptr_r;
    if (cmd.latch_in) begin
      req_r <= in_data.req_type;
      code_r <= in_data.char_code;
      addr_r <= in_data.cell_address;
    end
    if (cmd.out_load) begin
      out_r.cursor_column <= col_ext[CURSOR_W-1:0];
      out_r.cursor_row <= row_ext[CURSOR_W-1:0];
      out_r.cell_data <= (status.is_read && rd_in_range) ? rd_data_r : CODE_NUL;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/tcw_ctrl.sv
// Controller state machine: sequences requests, memory sweeps and the result beat.
module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  tcw_status_t status,
  output tcw_cmd_t    cmd
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_FILL = 3'd5;
  localparam logic [2:0] S_CLEAR = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_DONE) && out_free));
  assign accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.mem_we = 1'b1;
        cmd.wsel = WSEL_ZERO;
        cmd.ptr_inc = 1'b1;
        if (status.ptr_end) begin
          cmd.ptr_clr = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        if (status.is_put) begin
          if (status.code_cr) begin
            cmd.col_zero = 1'b1;
          end else if (!status.code_nul) begin
            if (!status.code_lf) begin
              cmd.mem_we = 1'b1;
              cmd.wsel = WSEL_CHAR;
            end
            // A character in the last column wraps exactly like a line feed.
            if (status.code_lf || status.col_wrap) begin
              cmd.col_zero = 1'b1;
              if (status.row_last) begin
                cmd.ptr_clr = 1'b1;
                state_nxt = S_SCROLL;
              end else begin
                cmd.row_inc = 1'b1;
              end
            end else begin
              cmd.col_inc = 1'b1;
            end
          end
        end else if (status.is_clear) begin
          cmd.ptr_clr = 1'b1;
          state_nxt = S_CLEAR;
        end else if (status.is_read) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RSEL_REQ;
        end
      end
      S_SCROLL: begin
        // Each cell is read one row below and written back in the following cycle.
        cmd.rd_en = 1'b1;
        cmd.rd_sel = RSEL_COPY;
        cmd.copy = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (status.ptr_copy_end) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd.mem_we = 1'b1;
        cmd.wsel = WSEL_SPACE;
        cmd.ptr_inc = 1'b1;
        if (status.ptr_end) begin
          cmd.ptr_clr = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel = WSEL_ZERO;
        cmd.ptr_inc = 1'b1;
        if (status.ptr_end) begin
          cmd.ptr_clr = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          if (accept) begin
            cmd.latch_in = 1'b1;
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/text_console_writer_core.sv
// Top level of the text console writer: controller, datapath and checks.
// The block keeps a COLUMNS x ROWS screen of byte cells and a cursor, and answers every
// request beat with one result beat carrying the cursor after the request and, for a
// read, the addressed cell. Put, carriage return, plain line feed, read and ignored
// requests pass through an execute state and a done state. A line feed or wrap on the
// last row scrolls the screen, and a clear zeroes it. After reset the screen is zeroed
// in a pass during which no request is taken. The scroll, the clear and that pass are
// bound by the single write port of the screen memory, which moves one cell per cycle.
// A finished result waits in an output register, so a new request is taken in the
// cycle that result leaves or while it is still held.
`include "text_console_writer_core_defines.svh"

module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 100,
  parameter int ROWS = 75
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tcw_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tcw_out_t out_data
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

  // In the cycle after a beat is taken, no further beat can be taken.
  `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  // Screen writes from the controller only happen while no input beat is taken.
  `TCW_ASSERT_SAME(a_no_write_on_accept, clk, rst_n, cmd.mem_we, in_stall)
  // A loaded result is always offered on the next cycle.
  `TCW_ASSERT_NEXT(a_load_shows_valid, clk, rst_n, cmd.out_load, out_valid)

endmodule
